@@ src/assert_macros.svh @@
// Assertion macros for the RTL files of the color bar generator.
// No dependencies; cbar_pipe, which checks its own logic, includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, switched off while reset is asserted.
`define CBAR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbar assertion failed");
// Clocked check that also holds during reset.
`define CBAR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cbar assertion failed");
`else
`define CBAR_ASSERT(label, clk, rst_n, prop)
`define CBAR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ src/cbar_pkg.sv @@
// Types, widths, constants and color tables of the color bar generator.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package cbar_pkg;

    localparam int X_W        = 13;
    localparam int Y_W        = 13;
    localparam int DIM_W      = 14;
    localparam int ROW_W      = 13;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int BAR_COUNT  = 7;
    localparam int COL_W      = 3;
    localparam int BAR_W_W    = 12;   // screen width / 7
    localparam int MID_W      = 11;   // band / 12

    localparam int CBAR_MAX_DIM = 8192;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [ROW_W-1:0] ROW_RESET    = '0;

    // Reciprocals for the constant divides, exact over the operand ranges used
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP7_W    = 15;
    localparam int RECIP3_W    = 16;
    localparam logic [RECIP7_W-1:0] RECIP7 = RECIP7_W'(18725);
    localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(43691);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT,
        CFG_FIRST_ROW
    } cfg_index_t;

    typedef enum logic [1:0] {
        PART_TOP,
        PART_MID,
        PART_BOT
    } part_t;

    // Geometry derived from the configuration, handed to the pixel pipeline
    typedef struct packed {
        logic [ROW_W-1:0]                  fr;
        logic [DIM_W-1:0]                  hgt;
        logic                              start_ok;
        logic [DIM_W-1:0]                  top_h;
        logic [MID_W-1:0]                  mid_h;
        logic [BAR_COUNT-1:0][DIM_W-1:0]   thr;     // bar_w * (k + 1)
    } cbar_geom_t;

    localparam logic [COLOR_W-1:0] UPPER_BAR_RGB [BAR_COUNT] = '{
        24'hC0C0C0, 24'hFFFF00, 24'h00FFFF, 24'h00FF00, 24'hFF00FF, 24'hFF0000, 24'h0000FF
    };
    localparam logic [COLOR_W-1:0] STRIP_BAR_RGB [BAR_COUNT] = '{
        24'h0000FF, 24'h000000, 24'hFF00FF, 24'h000000, 24'h00FFFF, 24'h000000, 24'hC0C0C0
    };
    localparam logic [COLOR_W-1:0] LOWER_BAR_RGB [BAR_COUNT] = '{
        24'h0D2B45, 24'hFFFFFF, 24'h1A0A2E, 24'h000000, 24'h000000, 24'h000000, 24'hC0C0C0
    };

    function automatic logic [COLOR_W-1:0] cbar_color(part_t part, logic [COL_W-1:0] col);
        logic [COLOR_W-1:0] color;
        color = '0;
        if (col < COL_W'(BAR_COUNT))
        begin
            unique case (part)
                PART_TOP: color = UPPER_BAR_RGB[col];
                PART_MID: color = STRIP_BAR_RGB[col];
                PART_BOT: color = LOWER_BAR_RGB[col];
                default:  color = '0;
            endcase
        end
        return color;
    endfunction

endpackage

`default_nettype wire

@@ src/cbar_req_if.sv @@
// Pixel coordinate channel of the color bar generator.
// Depends on cbar_pkg for the field widths.
`default_nettype none

interface cbar_req_if
    import cbar_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [X_W-1:0] pixel_x;
    logic [Y_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

@@ src/cbar_res_if.sv @@
// Pixel color result channel of the color bar generator.
// Depends on cbar_pkg for the field widths.
`default_nettype none

interface cbar_res_if
    import cbar_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               painted;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, output painted, output pixel_color, input ready);
    modport sink   (input valid, input painted, input pixel_color, output ready);
endinterface

`default_nettype wire

@@ src/cbar_cfg_if.sv @@
// Register write channel of the color bar generator.
// Depends on cbar_pkg for the index and data widths.
`default_nettype none

interface cbar_cfg_if
    import cbar_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/cbar_cfg.sv @@
// Configuration registers and the staged geometry derived from them.
// Depends on cbar_pkg and cbar_cfg_if.
`default_nettype none

module cbar_cfg
    import cbar_pkg::*;
#(
    parameter int MAX_DIM = CBAR_MAX_DIM
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cbar_cfg_if.sink    cfg,
    output cbar_geom_t  geom
);

    localparam int PROD7_W = DIM_W + RECIP7_W;
    localparam int PROD3_W = DIM_W + 1 + RECIP3_W;
    localparam int PRODM_W = DIM_W - 2 + RECIP3_W;

    logic [DIM_W-1:0] sw_reg;
    logic [DIM_W-1:0] sh_reg;
    logic [ROW_W-1:0] fr_reg;

    // level 1: clamped sizes and band
    logic [DIM_W-1:0] wid_reg, wid_next;
    logic [DIM_W-1:0] hgt_reg, hgt_next;
    logic [DIM_W-1:0] band_reg, band_next;
    logic             start_ok_reg, start_ok_next;

    // level 2: constant divides
    logic [BAR_W_W-1:0] bar_w_reg, bar_w_next;
    logic [DIM_W-1:0]   top_h_reg, top_h_next;
    logic [MID_W-1:0]   mid_h_reg, mid_h_next;
    logic [PROD7_W-1:0] prod7;
    logic [PROD3_W-1:0] prod3;
    logic [PRODM_W-1:0] prodm;

    // level 3: bar edges
    logic [BAR_COUNT-1:0][DIM_W-1:0] thr_reg, thr_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= WIDTH_RESET;
            sh_reg <= HEIGHT_RESET;
            fr_reg <= ROW_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_SCREEN_WIDTH:  sw_reg <= cfg.data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: sh_reg <= cfg.data[DIM_W-1:0];
                CFG_FIRST_ROW:     fr_reg <= cfg.data[ROW_W-1:0];
                default:           ;   // unknown register, dropped
            endcase
        end
    end

    always_comb
    begin
        wid_next      = (32'(sw_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sw_reg;
        hgt_next      = (32'(sh_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sh_reg;
        start_ok_next = {1'b0, fr_reg} < hgt_next;
        band_next     = hgt_next - {1'b0, fr_reg};
    end

    always_comb
    begin
        prod7      = PROD7_W'(wid_reg) * PROD7_W'(RECIP7);
        prod3      = PROD3_W'({band_reg, 1'b0}) * PROD3_W'(RECIP3);
        prodm      = PRODM_W'(band_reg[DIM_W-1:2]) * PRODM_W'(RECIP3);
        bar_w_next = prod7[RECIP_SHIFT +: BAR_W_W];
        top_h_next = prod3[RECIP_SHIFT +: DIM_W];
        mid_h_next = prodm[RECIP_SHIFT +: MID_W];
    end

    always_comb
    begin
        for (int k = 0; k < BAR_COUNT; k++)
        begin
            thr_next[k] = DIM_W'(32'(bar_w_reg) * (k + 1));
        end
    end

    // Derived values follow the registers every cycle; no reset needed
    always_ff @(posedge clk)
    begin
        wid_reg      <= wid_next;
        hgt_reg      <= hgt_next;
        band_reg     <= band_next;
        start_ok_reg <= start_ok_next;
        bar_w_reg    <= bar_w_next;
        top_h_reg    <= top_h_next;
        mid_h_reg    <= mid_h_next;
        thr_reg      <= thr_next;
    end

    always_comb
    begin
        geom.fr       = fr_reg;
        geom.hgt      = hgt_reg;
        geom.start_ok = start_ok_reg;
        geom.top_h    = top_h_reg;
        geom.mid_h    = mid_h_reg;
        geom.thr      = thr_reg;
    end

endmodule

`default_nettype wire

@@ src/cbar_pipe.sv @@
// Six-stage pixel pipeline: row checks, part select, bar index, color lookup.
// Depends on cbar_pkg, cbar_req_if, cbar_res_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cbar_pipe
    import cbar_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  cbar_geom_t  geom,
    cbar_req_if.sink    req,
    cbar_res_if.source  rsp
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG-1:0] adv;

    // stage 0: captured coordinate
    logic [X_W-1:0] x_s0_reg;
    logic [Y_W-1:0] y_s0_reg;
    // stage 1: row relative to the pattern start
    logic [X_W-1:0]   x_s1_reg;
    logic [Y_W-1:0]   y_s1_reg;
    logic [ROW_W-1:0] rel_s1_reg;
    logic             above_s1_reg;
    // stage 2: vertical coverage
    logic [X_W-1:0]   x_s2_reg;
    logic [ROW_W-1:0] rel_s2_reg;
    logic             ok_s2_reg;
    // stage 3: part of the band
    logic [X_W-1:0] x_s3_reg;
    logic           ok_s3_reg;
    part_t          part_s3_reg, part_s3_next;
    logic [DIM_W-1:0] rel_off;
    // stage 4: bar index
    logic             ok_s4_reg, ok_s4_next;
    part_t            part_s4_reg;
    logic [COL_W-1:0] col_s4_reg, col_s4_next;
    logic [BAR_COUNT-2:0] ge;
    // stage 5: result
    logic               painted_s5_reg;
    logic [COLOR_W-1:0] color_s5_reg;

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || rsp.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = req.valid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    assign req.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        rel_off = {1'b0, rel_s2_reg} - geom.top_h;
        if ({1'b0, rel_s2_reg} < geom.top_h)
        begin
            part_s3_next = PART_TOP;
        end
        else if (rel_off < DIM_W'(geom.mid_h))
        begin
            part_s3_next = PART_MID;
        end
        else
        begin
            part_s3_next = PART_BOT;
        end
    end

    always_comb
    begin
        for (int k = 0; k < BAR_COUNT - 1; k++)
        begin
            ge[k] = {1'b0, x_s3_reg} >= geom.thr[k];
        end
        col_s4_next = COL_W'($countones(ge));
        // beyond seven bar widths, or a zero bar width, stays unpainted
        ok_s4_next  = ok_s3_reg && ({1'b0, x_s3_reg} < geom.thr[BAR_COUNT-1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x_s0_reg <= req.pixel_x;
            y_s0_reg <= req.pixel_y;
        end
        if (adv[1])
        begin
            x_s1_reg     <= x_s0_reg;
            y_s1_reg     <= y_s0_reg;
            rel_s1_reg   <= y_s0_reg - geom.fr;
            above_s1_reg <= y_s0_reg < geom.fr;
        end
        if (adv[2])
        begin
            x_s2_reg   <= x_s1_reg;
            rel_s2_reg <= rel_s1_reg;
            ok_s2_reg  <= !above_s1_reg && geom.start_ok && ({1'b0, y_s1_reg} < geom.hgt);
        end
        if (adv[3])
        begin
            x_s3_reg    <= x_s2_reg;
            ok_s3_reg   <= ok_s2_reg;
            part_s3_reg <= part_s3_next;
        end
        if (adv[4])
        begin
            ok_s4_reg   <= ok_s4_next;
            part_s4_reg <= part_s3_reg;
            col_s4_reg  <= col_s4_next;
        end
        if (adv[5])
        begin
            painted_s5_reg <= ok_s4_reg;
            color_s5_reg   <= ok_s4_reg ? cbar_color(part_s4_reg, col_s4_reg) : '0;
        end
    end

    assign rsp.valid       = vld_reg[NSTG-1];
    assign rsp.painted     = painted_s5_reg;
    assign rsp.pixel_color = color_s5_reg;

    // items in flight change only by what is accepted and delivered
    `CBAR_ASSERT(a_item_count, clk, rst_n, 1'b1 |=> ($countones(vld_reg) == $countones($past(vld_reg)) + int'($past(req.valid && req.ready)) - int'($past(rsp.valid && rsp.ready))))
    `CBAR_ASSERT(a_col_range, clk, rst_n, vld_reg[4] && ok_s4_reg |-> col_s4_reg < COL_W'(BAR_COUNT))
    `CBAR_ASSERT(a_stall_holds, clk, rst_n, vld_reg[4] && vld_reg[5] && !rsp.ready |=> vld_reg[4] && $stable(col_s4_reg) && $stable(ok_s4_reg))
    `CBAR_ASSERT_ALWAYS(a_unpainted_black, clk, vld_reg[5] && !painted_s5_reg |-> color_s5_reg == '0)

endmodule

`default_nettype wire

@@ src/color_bar_pattern_generator.sv @@
// Top level of the color bar test pattern generator.
// Depends on cbar_pkg, the three channel interfaces, cbar_cfg and cbar_pipe.
//
// Channel  Dir  Payload                          Accepted when
// cfg      in   index[1:0], data[13:0]           cfg.valid && cfg.ready (always ready)
// req      in   pixel_x[12:0], pixel_y[12:0]     req.valid && req.ready
// rsp      out  painted, pixel_color[23:0]       rsp.valid && rsp.ready
//
// One pixel per cycle sustained while rsp is ready; cbar_pipe has six register
// stages, and each accepted item moves through them in order, stage 0 to stage 5.
// Register geometry is staged via clamped sizes, constant divides and bar edges,
// and meets each item where used, so a write is in effect for the very next item.
// A stall at rsp holds each full stage whose later stages are all full; others still
// advance and fill, so ready at req drops only when all six stages hold items.
// rst_n clears the registers to 640 x 480, first row 0, and empties the pipeline.
`default_nettype none

module color_bar_pattern_generator
    import cbar_pkg::*;
#(
    parameter int MAX_DIM = CBAR_MAX_DIM
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cbar_cfg_if.sink   cfg,
    cbar_req_if.sink   req,
    cbar_res_if.source rsp
);

    cbar_geom_t geom;

    cbar_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .geom  (geom)
    );

    cbar_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .geom  (geom),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
